>>> hw/rtl/array_max_priority_queue_macros.svh
// Assertion macros of the priority queue top level
`ifndef ARRAY_MAX_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_MAX_PRIORITY_QUEUE_MACROS_SVH

// Check a consequence in the same cycle as its antecedent
`define AMPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent
`define AMPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ampq_pkg.sv
// Shared constants and types of the array max priority queue
`timescale 1ns / 1ps

package ampq_pkg;

   // Default sizing
   localparam int CAPACITY_DEF  = 16;
   localparam int KEY_WIDTH_DEF = 32;

   // Fixed field widths of the channels
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // One response as it leaves the engine
   typedef struct packed {
      logic [VALUE_W-1:0]  top_value;
      logic [COUNT_W-1:0]  held_count;
      logic [STATUS_W-1:0] status;
   } ampq_result_type;

   // Controls from the engine to the maximum tracker
   typedef struct packed {
      logic start;
      logic scan_hit;
      logic shift_hit;
   } ampq_scan_ctl_type;

endpackage

>>> hw/rtl/array_max_priority_queue.sv
// Top level of the array max priority queue
//
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    req_mode, req_value
//   rsp      out  rsp_valid/stall    rsp_top_value, rsp_held_count, rsp_status
//
// Insert, clear, no-op and remove on an empty queue finish in the cycle the request
// is taken. A remove scans the held keys for the maximum, seeks to the slot behind it,
// then shifts the keys behind it down one slot, all through the one read port of the
// key memory.
// Reset empties the queue at once through the held count; no memory sweep is needed.
// A response waits in the output register while rsp_stall is high; one more request
// may complete behind it and holds in the engine.
`timescale 1ns / 1ps

`include "array_max_priority_queue_macros.svh"

module array_max_priority_queue
   import ampq_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [VALUE_W-1:0]  rsp_top_value,
   output logic [COUNT_W-1:0]  rsp_held_count,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW = $clog2(CAPACITY);

   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [KEY_WIDTH-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [KEY_WIDTH-1:0] mem_rd_data;
   logic                 out_free;
   logic                 res_push;
   ampq_result_type      res;

   logic                 rsp_valid_ff, rsp_valid_in;
   ampq_result_type      rsp_ff;

   ampq_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ampq_engine #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_value   (req_value),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .out_free    (out_free),
      .res_push    (res_push),
      .res         (res)
   );

   // Output register frees when empty or when its response is taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (res_push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the response payload
   always_ff @(posedge clock) begin
      if (res_push) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_top_value  = rsp_ff.top_value;
   assign rsp_held_count = rsp_ff.held_count;
   assign rsp_status     = rsp_ff.status;

   // A dropped insert only happens with every slot taken
   `AMPQ_ASSERT_NOW(a_full_count, clock, reset, rsp_valid_ff && rsp_status == STAT_FULL, rsp_held_count == COUNT_W'(CAPACITY), "full status with a free slot")

   // A remove on an empty queue reports an empty queue
   `AMPQ_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid_ff && rsp_status == STAT_EMPTY, rsp_held_count == '0 && rsp_top_value == '0, "empty status with keys held")

   // A clear taken with the output free shows an empty queue next cycle
   `AMPQ_ASSERT_NEXT(a_clear_resp, clock, reset, req_valid && !req_stall && req_mode == MODE_CLEAR && out_free, rsp_valid_ff && rsp_held_count == '0 && rsp_top_value == '0 && rsp_status == STAT_OK, "clear did not empty the queue")

endmodule

>>> hw/rtl/ampq_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps

module ampq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ampq_scan.sv
// Tracker of the earliest largest key and of the highest key left after removal
`timescale 1ns / 1ps

module ampq_scan
   import ampq_pkg::*;
#(
   parameter int ADDR_W    = 4,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic                 clock,
   input  ampq_scan_ctl_type    ctl,
   input  logic [ADDR_W-1:0]    data_idx,
   input  logic [KEY_WIDTH-1:0] data,
   output logic [ADDR_W-1:0]    best_idx,
   output logic [KEY_WIDTH-1:0] new_top
);

   logic [ADDR_W-1:0]    best_idx_ff;
   logic [KEY_WIDTH-1:0] best_val_ff;
   logic [KEY_WIDTH-1:0] prefix_max_ff;
   logic [KEY_WIDTH-1:0] shift_max_ff;
   logic                 first;

   assign first = (data_idx == '0);

   // Track the earliest maximum; the old best is the largest key in front of the new one
   always_ff @(posedge clock) begin
      if (ctl.scan_hit && (first || data > best_val_ff)) begin
         prefix_max_ff <= first ? '0 : best_val_ff;
         best_val_ff   <= data;
         best_idx_ff   <= data_idx;
      end
   end

   // Track the largest key behind the removed one while it shifts down
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         shift_max_ff <= '0;
      end else if (ctl.shift_hit && data > shift_max_ff) begin
         shift_max_ff <= data;
      end
   end

   assign best_idx = best_idx_ff;
   assign new_top  = (prefix_max_ff > shift_max_ff) ? prefix_max_ff : shift_max_ff;

endmodule

>>> hw/rtl/ampq_engine.sv
// Sequencer that runs insert, remove and clear against the key memory
`timescale 1ns / 1ps

module ampq_engine
   import ampq_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [MODE_W-1:0]           req_mode,
   input  logic [VALUE_W-1:0]          req_value,
   output logic                        mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
   output logic [KEY_WIDTH-1:0]        mem_wr_data,
   output logic                        mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
   input  logic [KEY_WIDTH-1:0]        mem_rd_data,
   input  logic                        out_free,
   output logic                        res_push,
   output ampq_result_type             res
);

   localparam int AW = $clog2(CAPACITY);
   localparam int OW = $clog2(CAPACITY + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_SEEK   = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_RESULT = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [OW-1:0]        occ_ff, occ_in;
   logic [KEY_WIDTH-1:0] top_ff, top_in;
   logic [OW-1:0]        rd_cnt_ff, rd_cnt_in;
   logic                 data_valid_ff;
   logic [AW-1:0]        data_idx_ff;
   ampq_result_type      res_hold_ff, res_hold_in;

   ampq_scan_ctl_type    scan_ctl;
   logic [AW-1:0]        best_idx;
   logic [KEY_WIDTH-1:0] new_top;

   logic [63:0]          value_wide;
   logic [KEY_WIDTH-1:0] key;
   logic [63:0]          top_wide;
   logic [31:0]          occ_wide;
   logic                 done;
   logic [STATUS_W-1:0]  status;
   ampq_result_type      res_now;

   // Mask the request value to the key width
   assign value_wide = 64'(req_value);
   assign key        = value_wide[KEY_WIDTH-1:0];

   ampq_scan #(
      .ADDR_W    (AW),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_scan (
      .clock    (clock),
      .ctl      (scan_ctl),
      .data_idx (data_idx_ff),
      .data     (mem_rd_data),
      .best_idx (best_idx),
      .new_top  (new_top)
   );

   // Sequence the operation
   always_comb begin
      state_in    = state_ff;
      occ_in      = occ_ff;
      top_in      = top_ff;
      rd_cnt_in   = rd_cnt_ff;
      res_hold_in = res_hold_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_cnt_ff[AW-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = occ_ff[AW-1:0];
      mem_wr_data = key;
      scan_ctl    = '0;
      done        = 1'b0;
      status      = STAT_OK;
      res_push    = 1'b0;
      req_stall   = (state_ff != S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_mode)
                  MODE_INSERT: begin
                     done = 1'b1;
                     if (key != '0) begin
                        if (occ_ff >= OW'(CAPACITY)) begin
                           status = STAT_FULL;
                        end else begin
                           mem_wr_en = 1'b1;
                           occ_in    = occ_ff + OW'(1);
                           top_in    = (key > top_ff) ? key : top_ff;
                        end
                     end
                  end
                  MODE_REMOVE: begin
                     if (occ_ff == '0) begin
                        done   = 1'b1;
                        status = STAT_EMPTY;
                     end else begin
                        // Start the scan at slot zero
                        mem_rd_en      = 1'b1;
                        mem_rd_addr    = '0;
                        rd_cnt_in      = OW'(1);
                        scan_ctl.start = 1'b1;
                        state_in       = S_SCAN;
                     end
                  end
                  MODE_CLEAR: begin
                     done   = 1'b1;
                     occ_in = '0;
                     top_in = '0;
                  end
                  MODE_NOP: begin
                     done = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            scan_ctl.scan_hit = data_valid_ff;
            if (rd_cnt_ff < occ_ff) begin
               mem_rd_en = 1'b1;
               rd_cnt_in = rd_cnt_ff + OW'(1);
            end
            if (data_valid_ff && OW'(data_idx_ff) == occ_ff - OW'(1)) begin
               state_in = S_SEEK;
            end
         end
         S_SEEK: begin
            // Resume reading just behind the removed slot
            rd_cnt_in = OW'(best_idx) + OW'(1);
            state_in  = S_SHIFT;
         end
         S_SHIFT: begin
            scan_ctl.shift_hit = data_valid_ff;
            if (data_valid_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = data_idx_ff - AW'(1);
               mem_wr_data = mem_rd_data;
            end
            if (rd_cnt_ff < occ_ff) begin
               mem_rd_en = 1'b1;
               rd_cnt_in = rd_cnt_ff + OW'(1);
            end else if (!data_valid_ff) begin
               done   = 1'b1;
               occ_in = occ_ff - OW'(1);
               top_in = new_top;
            end
         end
         S_RESULT: begin
            res_push = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Hand over the finished response, or hold it until the output frees
      if (done) begin
         if (out_free) begin
            res_push = 1'b1;
            state_in = S_IDLE;
         end else begin
            res_hold_in = res_now;
            state_in    = S_RESULT;
         end
      end
   end

   // Build the response from the updated state
   always_comb begin
      top_wide           = 64'(top_in);
      occ_wide           = 32'(occ_in);
      res_now.top_value  = top_wide[VALUE_W-1:0];
      res_now.held_count = occ_wide[COUNT_W-1:0];
      res_now.status     = status;
   end

   assign res = (state_ff == S_RESULT) ? res_hold_ff : res_now;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         top_ff        <= '0;
         data_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         top_ff        <= top_in;
         data_valid_ff <= mem_rd_en;
      end
   end

   // Read pointer, returning index and held response
   always_ff @(posedge clock) begin
      rd_cnt_ff   <= rd_cnt_in;
      data_idx_ff <= mem_rd_addr;
      res_hold_ff <= res_hold_in;
   end

endmodule
